>>> sv/gyro_rate_conditioner_macros.svh
// Assertion macros for the gyro rate conditioner.
// Define ASSERT_OFF to compile all checks away.
`ifndef GYRO_RATE_CONDITIONER_MACROS_SVH
`define GYRO_RATE_CONDITIONER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define GRC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gyro rate conditioner check failed");
// Next-cycle implication, disabled during reset
`define GRC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gyro rate conditioner check failed");
`else
`define GRC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GRC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> sv/grc_pkg.sv
package grc_pkg;

  // Fixed field widths
  localparam int SPEED_W = 24;
  localparam int DZ_W    = 16;
  localparam int SSL_W   = 23;
  localparam int SRL_W   = 19;
  localparam int STEP_W  = 16;
  localparam int ALPHA_W = 8;
  localparam int FRAC_W  = 8;
  localparam int ROUND_HALF = 128;

  // Filter coefficients, Q0.8
  localparam logic [ALPHA_W-1:0] COEF_X    = 8'd154;
  localparam logic [ALPHA_W-1:0] COEF_NAV  = 8'd230;
  localparam logic [ALPHA_W-1:0] COEF_CTRL = 8'd51;

  // Step counter of the serial multipliers
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] FILT_LAST = CNT_W'(ALPHA_W - 1);
  localparam logic [CNT_W-1:0] YAW_LAST  = CNT_W'(STEP_W - 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X          = 3'd0,
    CFG_OFFSET_Y          = 3'd1,
    CFG_OFFSET_Z          = 3'd2,
    CFG_DEAD_ZONE         = 3'd3,
    CFG_STILL_SPEED_LIMIT = 3'd4,
    CFG_STILL_RATE_LIMIT  = 3'd5,
    CFG_YAW_STEP          = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [DZ_W-1:0]   DEAD_ZONE_RST   = 16'd77;
  localparam logic [SSL_W-1:0]  SPEED_LIMIT_RST = 23'd1280;
  localparam logic [SRL_W-1:0]  RATE_LIMIT_RST  = 19'd1280;
  localparam logic [STEP_W-1:0] YAW_STEP_RST    = 16'd131;

endpackage

>>> sv/gyro_rate_conditioner.sv
// A beat passes PREP, DIFF, FILT, UPD, YAW and DONE before its result is registered;
// a new beat is taken only in IDLE, once the output register was free in DONE. An
// 8-step bit-serial alpha multiply and a 16-step bit-serial yaw_step multiply
// set the pace. A finished beat waits in the output register meanwhile.
// Reset (rst, synchronous): filters and yaw clear to zero, registers take their
// defaults, no output beat pending.
`include "gyro_rate_conditioner_macros.svh"

module gyro_rate_conditioner #(
  parameter int RATE_WIDTH = 20,
  parameter int YAW_WIDTH  = 40,
  localparam int CFG_W  = (RATE_WIDTH > grc_pkg::SSL_W) ? RATE_WIDTH : grc_pkg::SSL_W,
  localparam int IN_W   = ((3 * RATE_WIDTH + 2 * grc_pkg::SPEED_W + 7) / 8) * 8,
  localparam int OUT_W  = ((4 * RATE_WIDTH + YAW_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  // input sample stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // rate_x, rate_y, rate_z, speed_left, speed_right
  input  logic [IN_W-1:0]               s_axis_tdata,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_rate_x, out_rate_y, out_rate_z_nav, out_rate_z_ctrl, yaw_angle
  output logic [OUT_W-1:0]              m_axis_tdata
);

  localparam int SPW    = grc_pkg::SPEED_W;
  localparam int DIFF_W = RATE_WIDTH + 1;
  localparam int SUM_W  = RATE_WIDTH + 2;
  localparam int PROD_W = DIFF_W + grc_pkg::ALPHA_W;
  localparam int YP_W   = RATE_WIDTH + grc_pkg::STEP_W + 1;
  localparam int EXT_W  = (YAW_WIDTH > YP_W) ? YAW_WIDTH : YP_W;
  localparam int CMP_W  = (DIFF_W > SPW) ? DIFF_W : SPW;

  localparam logic signed [RATE_WIDTH-1:0] RATE_MAX = {1'b0, {(RATE_WIDTH-1){1'b1}}};
  localparam logic signed [RATE_WIDTH-1:0] RATE_MIN = {1'b1, {(RATE_WIDTH-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] ROUND_P = PROD_W'(grc_pkg::ROUND_HALF);
  localparam logic signed [YP_W-1:0]   ROUND_Y = YP_W'(grc_pkg::ROUND_HALF);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIFF,
    ST_FILT,
    ST_UPD,
    ST_YAW,
    ST_DONE
  } state_t;

  // Magnitude of a sign-extended value
  function automatic logic [CMP_W-1:0] mag(input logic signed [CMP_W-1:0] v);
    return v[CMP_W-1] ? CMP_W'(-v) : CMP_W'(v);
  endfunction

  // Saturate an offset difference to the rate range
  function automatic logic signed [RATE_WIDTH-1:0] sat_diff(input logic signed [DIFF_W-1:0] v);
    if (v[DIFF_W-1] == v[DIFF_W-2]) return v[RATE_WIDTH-1:0];
    return v[DIFF_W-1] ? RATE_MIN : RATE_MAX;
  endfunction

  // True when a filter sum fits the rate range
  function automatic logic sum_fits(input logic signed [SUM_W-1:0] v);
    return (v[SUM_W-1:RATE_WIDTH-1] == 3'b000) || (v[SUM_W-1:RATE_WIDTH-1] == 3'b111);
  endfunction

  function automatic logic signed [RATE_WIDTH-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    if (sum_fits(v)) return v[RATE_WIDTH-1:0];
    return v[SUM_W-1] ? RATE_MIN : RATE_MAX;
  endfunction

  // Configuration registers
  logic signed [RATE_WIDTH-1:0]     offset_x;
  logic signed [RATE_WIDTH-1:0]     offset_y;
  logic signed [RATE_WIDTH-1:0]     offset_z;
  logic [grc_pkg::DZ_W-1:0]         dead_zone;
  logic [grc_pkg::SSL_W-1:0]        still_speed_limit;
  logic [grc_pkg::SRL_W-1:0]        still_rate_limit;
  logic [grc_pkg::STEP_W-1:0]       yaw_step;

  // Sequencer and captured sample
  state_t                           state;
  logic [grc_pkg::CNT_W-1:0]        cnt;
  logic signed [RATE_WIDTH-1:0]     in_rx;
  logic signed [RATE_WIDTH-1:0]     in_ry;
  logic signed [RATE_WIDTH-1:0]     in_rz;
  logic signed [SPW-1:0]            in_sl;
  logic signed [SPW-1:0]            in_sr;
  logic signed [RATE_WIDTH-1:0]     g_x;
  logic signed [RATE_WIDTH-1:0]     g_y;
  logic signed [RATE_WIDTH-1:0]     g_z;

  // Filter state and serial multipliers
  logic signed [RATE_WIDTH-1:0]     smooth_x;
  logic signed [RATE_WIDTH-1:0]     smooth_z_nav;
  logic signed [RATE_WIDTH-1:0]     smooth_z_ctrl;
  logic signed [PROD_W-1:0]         mc_x;
  logic signed [PROD_W-1:0]         mc_n;
  logic signed [PROD_W-1:0]         mc_c;
  logic [grc_pkg::ALPHA_W-1:0]      mp_x;
  logic [grc_pkg::ALPHA_W-1:0]      mp_n;
  logic [grc_pkg::ALPHA_W-1:0]      mp_c;
  logic signed [PROD_W-1:0]         acc_x;
  logic signed [PROD_W-1:0]         acc_n;
  logic signed [PROD_W-1:0]         acc_c;

  // Yaw integrator and its serial multiplier
  logic [YAW_WIDTH-1:0]             yaw_accum;
  logic signed [YP_W-1:0]           ymc;
  logic [grc_pkg::STEP_W-1:0]       ymp;
  logic signed [YP_W-1:0]           yacc;

  // Offset removal, stillness lock and dead zone
  logic signed [DIFF_W-1:0]         dx;
  logic signed [DIFF_W-1:0]         dy;
  logic signed [DIFF_W-1:0]         dz;
  logic signed [RATE_WIDTH-1:0]     sx;
  logic signed [RATE_WIDTH-1:0]     sy;
  logic                             still;
  logic                             lock;

  assign dx = DIFF_W'(in_rx) - DIFF_W'(offset_x);
  assign dy = DIFF_W'(in_ry) - DIFF_W'(offset_y);
  assign dz = DIFF_W'(in_rz) - DIFF_W'(offset_z);
  assign sx = sat_diff(dx);
  assign sy = sat_diff(dy);
  assign still = (mag(CMP_W'(in_sl)) < CMP_W'(still_speed_limit)) &&
                 (mag(CMP_W'(in_sr)) < CMP_W'(still_speed_limit));
  assign lock  = still && (mag(CMP_W'(dz)) < CMP_W'(still_rate_limit));

  // Round the filter products and add them to the last values
  logic signed [PROD_W-1:0]         rsum_x, rsum_n, rsum_c;
  logic signed [PROD_W-1:0]         rnd_x, rnd_n, rnd_c;
  logic signed [SUM_W-1:0]          sum_x, sum_n, sum_c;
  logic signed [RATE_WIDTH-1:0]     nav_new;
  logic                             fit_x, fit_n, fit_c;

  assign rsum_x = acc_x + ROUND_P;
  assign rsum_n = acc_n + ROUND_P;
  assign rsum_c = acc_c + ROUND_P;
  assign rnd_x  = rsum_x >>> grc_pkg::FRAC_W;
  assign rnd_n  = rsum_n >>> grc_pkg::FRAC_W;
  assign rnd_c  = rsum_c >>> grc_pkg::FRAC_W;
  assign sum_x  = SUM_W'(smooth_x) + SUM_W'(rnd_x);
  assign sum_n  = SUM_W'(smooth_z_nav) + SUM_W'(rnd_n);
  assign sum_c  = SUM_W'(smooth_z_ctrl) + SUM_W'(rnd_c);
  assign fit_x  = sum_fits(sum_x);
  assign fit_n  = sum_fits(sum_n);
  assign fit_c  = sum_fits(sum_c);
  assign nav_new = sat_sum(sum_n);

  // Round the yaw product to Q16 and wrap into the accumulator
  logic signed [YP_W-1:0]           ysum;
  logic signed [YP_W-1:0]           ydelta;
  logic signed [EXT_W-1:0]          delta_ext;
  logic [YAW_WIDTH-1:0]             yaw_next;
  logic                             out_free;

  assign ysum      = yacc + ROUND_Y;
  assign ydelta    = ysum >>> grc_pkg::FRAC_W;
  assign delta_ext = EXT_W'(ydelta);
  assign yaw_next  = yaw_accum + delta_ext[YAW_WIDTH-1:0];
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x          <= '0;
      offset_y          <= '0;
      offset_z          <= '0;
      dead_zone         <= grc_pkg::DEAD_ZONE_RST;
      still_speed_limit <= grc_pkg::SPEED_LIMIT_RST;
      still_rate_limit  <= grc_pkg::RATE_LIMIT_RST;
      yaw_step          <= grc_pkg::YAW_STEP_RST;
    end else if (cfg_we) begin
      case (grc_pkg::cfg_reg_t'(cfg_index))
        grc_pkg::CFG_OFFSET_X:          offset_x <= cfg_data[RATE_WIDTH-1:0];
        grc_pkg::CFG_OFFSET_Y:          offset_y <= cfg_data[RATE_WIDTH-1:0];
        grc_pkg::CFG_OFFSET_Z:          offset_z <= cfg_data[RATE_WIDTH-1:0];
        grc_pkg::CFG_DEAD_ZONE:         dead_zone <= cfg_data[grc_pkg::DZ_W-1:0];
        grc_pkg::CFG_STILL_SPEED_LIMIT: still_speed_limit <= cfg_data[grc_pkg::SSL_W-1:0];
        grc_pkg::CFG_STILL_RATE_LIMIT:  still_rate_limit <= cfg_data[grc_pkg::SRL_W-1:0];
        grc_pkg::CFG_YAW_STEP:          yaw_step <= cfg_data[grc_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, serial multipliers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      smooth_x      <= '0;
      smooth_z_nav  <= '0;
      smooth_z_ctrl <= '0;
      yaw_accum     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // raise the output beat from the final step, drop it once taken
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            in_rx <= s_axis_tdata[RATE_WIDTH-1:0];
            in_ry <= s_axis_tdata[2*RATE_WIDTH-1:RATE_WIDTH];
            in_rz <= s_axis_tdata[3*RATE_WIDTH-1:2*RATE_WIDTH];
            in_sl <= s_axis_tdata[3*RATE_WIDTH+SPW-1:3*RATE_WIDTH];
            in_sr <= s_axis_tdata[3*RATE_WIDTH+2*SPW-1:3*RATE_WIDTH+SPW];
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          g_x   <= (mag(CMP_W'(sx)) < CMP_W'(dead_zone)) ? '0 : sx;
          g_y   <= (mag(CMP_W'(sy)) < CMP_W'(dead_zone)) ? '0 : sy;
          g_z   <= lock ? '0 : sat_diff(dz);
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          // filter as last + alpha * (d - last)
          mc_x  <= PROD_W'(g_x) - PROD_W'(smooth_x);
          mc_n  <= PROD_W'(g_z) - PROD_W'(smooth_z_nav);
          mc_c  <= PROD_W'(g_z) - PROD_W'(smooth_z_ctrl);
          mp_x  <= grc_pkg::COEF_X;
          mp_n  <= grc_pkg::COEF_NAV;
          mp_c  <= grc_pkg::COEF_CTRL;
          acc_x <= '0;
          acc_n <= '0;
          acc_c <= '0;
          cnt   <= '0;
          state <= ST_FILT;
        end
        ST_FILT: begin
          // one alpha bit per cycle, LSB first
          acc_x <= acc_x + (mp_x[0] ? mc_x : '0);
          acc_n <= acc_n + (mp_n[0] ? mc_n : '0);
          acc_c <= acc_c + (mp_c[0] ? mc_c : '0);
          mc_x  <= mc_x <<< 1;
          mc_n  <= mc_n <<< 1;
          mc_c  <= mc_c <<< 1;
          mp_x  <= mp_x >> 1;
          mp_n  <= mp_n >> 1;
          mp_c  <= mp_c >> 1;
          cnt   <= cnt + 1'b1;
          if (cnt == grc_pkg::FILT_LAST) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          smooth_x      <= sat_sum(sum_x);
          smooth_z_nav  <= nav_new;
          smooth_z_ctrl <= sat_sum(sum_c);
          ymc           <= YP_W'(nav_new);
          ymp           <= yaw_step;
          yacc          <= '0;
          cnt           <= '0;
          state         <= ST_YAW;
        end
        ST_YAW: begin
          // one yaw_step bit per cycle, LSB first
          yacc <= yacc + (ymp[0] ? ymc : '0);
          ymc  <= ymc <<< 1;
          ymp  <= ymp >> 1;
          cnt  <= cnt + 1'b1;
          if (cnt == grc_pkg::YAW_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            yaw_accum     <= yaw_next;
            m_axis_tdata  <= OUT_W'({yaw_next, smooth_z_ctrl, smooth_z_nav, g_y, smooth_x});
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A taken input beat starts the offset stage next cycle
  `GRC_ASSERT_NXT(a_accept_starts, clk, rst, s_axis_tvalid && s_axis_tready, state == ST_PREP)
  // Filter outputs are convex blends and never need saturation
  `GRC_ASSERT_IMP(a_filter_fits, clk, rst, state == ST_UPD, fit_x && fit_n && fit_c)
  // Yaw moves only when a result is handed to the output register
  `GRC_ASSERT_NXT(a_yaw_hold, clk, rst, !(state == ST_DONE && out_free), $stable(yaw_accum))
  // An output beat appears only from the final step
  `GRC_ASSERT_IMP(a_out_from_done, clk, rst, $rose(m_axis_tvalid), $past(state) == ST_DONE)

endmodule

>>> tb/sv/tb_gyro_rate_conditioner.sv
`timescale 1ns / 100ps

module tb_gyro_rate_conditioner;

  localparam int RATE_W = 20;
  localparam int YAW_W = 40;
  localparam int SPEED_W = grc_pkg::SPEED_W;
  localparam int IDX_W = grc_pkg::CFG_IDX_W;
  localparam int CFG_W = (RATE_W > grc_pkg::SSL_W) ? RATE_W : grc_pkg::SSL_W;
  localparam int IN_W = ((3 * RATE_W + 2 * SPEED_W + 7) / 8) * 8;
  localparam int OUT_W = ((4 * RATE_W + YAW_W + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RUN_ITEMS = 150;
  localparam int TAIL_ITEMS = 100;
  localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;

  // Filter gains, Q0.8
  localparam longint X_GAIN = 154;
  localparam longint NAV_GAIN = 230;
  localparam longint CTRL_GAIN = 51;
  localparam longint RATE_MAX = (longint'(1) << (RATE_W - 1)) - 1;
  localparam longint RATE_MIN = -RATE_MAX - 1;
  localparam longint YAW_MAX = (longint'(1) << (YAW_W - 1)) - 1;
  localparam longint YAW_MIN = -YAW_MAX - 1;

  // One input beat, first field in the lowest bits
  typedef struct packed {
    logic [IN_W-3*RATE_W-2*SPEED_W-1:0] spare;
    logic signed [SPEED_W-1:0] speed_right;
    logic signed [SPEED_W-1:0] speed_left;
    logic signed [RATE_W-1:0] rate_z;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_x;
  } gyro_sample_t;

  // One output beat, first field in the lowest bits
  typedef struct packed {
    logic signed [YAW_W-1:0] yaw_angle;
    logic signed [RATE_W-1:0] rate_z_ctrl;
    logic signed [RATE_W-1:0] rate_z_nav;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_x;
  } rate_result_t;

  // Conditioner model plus the queue of results still owed by the block
  class rate_scoreboard;
    longint offset_x, offset_y, offset_z;
    longint dead_zone, speed_limit, rate_limit, yaw_step;
    longint filt_x, filt_nav, filt_ctrl;
    logic [YAW_W-1:0] yaw;
    rate_result_t owed_q[$];
    int errors, checked, locks, clipped, wraps;

    function new();
      offset_x = 0;
      offset_y = 0;
      offset_z = 0;
      dead_zone = 77;
      speed_limit = 1280;
      rate_limit = 1280;
      yaw_step = 131;
      filt_x = 0;
      filt_nav = 0;
      filt_ctrl = 0;
      yaw = '0;
    endfunction

    function longint clamp_rate(longint v);
      if (v > RATE_MAX) return RATE_MAX;
      if (v < RATE_MIN) return RATE_MIN;
      return v;
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // First-order smoothing, round half up, floor shift
    function longint blend(longint d, longint last, longint gain);
      return clamp_rate((d * gain + last * (256 - gain) + 128) >>> 8);
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        grc_pkg::CFG_OFFSET_X: offset_x = longint'($signed(val[RATE_W-1:0]));
        grc_pkg::CFG_OFFSET_Y: offset_y = longint'($signed(val[RATE_W-1:0]));
        grc_pkg::CFG_OFFSET_Z: offset_z = longint'($signed(val[RATE_W-1:0]));
        grc_pkg::CFG_DEAD_ZONE: dead_zone = longint'(val[grc_pkg::DZ_W-1:0]);
        grc_pkg::CFG_STILL_SPEED_LIMIT: speed_limit = longint'(val[grc_pkg::SSL_W-1:0]);
        grc_pkg::CFG_STILL_RATE_LIMIT: rate_limit = longint'(val[grc_pkg::SRL_W-1:0]);
        grc_pkg::CFG_YAW_STEP: yaw_step = longint'(val[grc_pkg::STEP_W-1:0]);
        default: ;
      endcase
    endfunction

    function void note_sample(gyro_sample_t s);
      longint dx, dy, dz, gx, gy, gz, sl, sr, delta, full;
      bit still;
      rate_result_t r;
      dx = longint'($signed(s.rate_x)) - offset_x;
      dy = longint'($signed(s.rate_y)) - offset_y;
      dz = longint'($signed(s.rate_z)) - offset_z;
      sl = longint'($signed(s.speed_left));
      sr = longint'($signed(s.speed_right));
      gx = clamp_rate(dx);
      gy = clamp_rate(dy);
      if (gx != dx || gy != dy || clamp_rate(dz) != dz) clipped++;
      still = mag(sl) < speed_limit && mag(sr) < speed_limit;
      // lock z while parked and near its offset
      if (still && mag(dz) < rate_limit) begin
        gz = 0;
        locks++;
      end else begin
        gz = clamp_rate(dz);
      end
      if (mag(gx) < dead_zone) gx = 0;
      if (mag(gy) < dead_zone) gy = 0;
      filt_x = blend(gx, filt_x, X_GAIN);
      filt_nav = blend(gz, filt_nav, NAV_GAIN);
      filt_ctrl = blend(gz, filt_ctrl, CTRL_GAIN);
      // integrate heading, Q24 product rounded down to Q16
      delta = (filt_nav * yaw_step + 128) >>> 8;
      full = longint'($signed(yaw)) + delta;
      if (full > YAW_MAX || full < YAW_MIN) wraps++;
      yaw = yaw + YAW_W'(delta);
      r.rate_x = RATE_W'(filt_x);
      r.rate_y = RATE_W'(gy);
      r.rate_z_nav = RATE_W'(filt_nav);
      r.rate_z_ctrl = RATE_W'(filt_ctrl);
      r.yaw_angle = yaw;
      owed_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [YAW_W-1:0] want, logic [YAW_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("%s mismatch at result %0d: expected %h, got %h", name, checked, want, got);
      end
    endfunction

    function void check_result(rate_result_t got);
      rate_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing owed: %h", got);
        return;
      end
      want = owed_q.pop_front();
      checked++;
      compare_field("out_rate_x", want.rate_x, got.rate_x);
      compare_field("out_rate_y", want.rate_y, got.rate_y);
      compare_field("out_rate_z_nav", want.rate_z_nav, got.rate_z_nav);
      compare_field("out_rate_z_ctrl", want.rate_z_ctrl, got.rate_z_ctrl);
      compare_field("yaw_angle", want.yaw_angle, got.yaw_angle);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  rate_scoreboard sb;
  int gap_odds;
  int stall_odds;
  int settings;
  int quiet;

  gyro_rate_conditioner #(
    .RATE_WIDTH(RATE_W),
    .YAW_WIDTH(YAW_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: stall at random in bursts of random length
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Log accepted beats in order, check results, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(gyro_sample_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) sb.check_result(rate_result_t'(m_axis_tdata));
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("tb_gyro_rate_conditioner: errors");
        $finish;
      end
    end
  end

  function automatic gyro_sample_t mk(longint rx, longint ry, longint rz, longint sl, longint sr);
    gyro_sample_t s;
    s.spare = '0;
    s.rate_x = RATE_W'(rx);
    s.rate_y = RATE_W'(ry);
    s.rate_z = RATE_W'(rz);
    s.speed_left = SPEED_W'(sl);
    s.speed_right = SPEED_W'(sr);
    return s;
  endfunction

  // Random value within spread of center, held to the signed field range
  function automatic longint near(longint center, longint spread, int w);
    longint hi, lo, v;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    v = center + longint'($urandom_range(0, 32'(2 * spread))) - spread;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  // Mix of raw noise, parked samples and driving samples near the offsets
  function automatic gyro_sample_t random_sample();
    gyro_sample_t s;
    case ($urandom_range(0, 3))
      0: s = mk($urandom, $urandom, $urandom, $urandom, $urandom);
      1: s = mk(near(sb.offset_x, 2 * sb.dead_zone, RATE_W),
                near(sb.offset_y, 2 * sb.dead_zone, RATE_W),
                near(sb.offset_z, sb.rate_limit + 2, RATE_W),
                near(0, sb.speed_limit + 1, SPEED_W),
                near(0, sb.speed_limit + 1, SPEED_W));
      2: s = mk(near(sb.offset_x, 2 * sb.dead_zone + 4000, RATE_W),
                near(sb.offset_y, 2 * sb.dead_zone + 4000, RATE_W),
                near(sb.offset_z, sb.rate_limit + 4000, RATE_W),
                $urandom, $urandom);
      default: s = mk($urandom, $urandom, $urandom,
                      near(0, sb.speed_limit + 1, SPEED_W), $urandom);
    endcase
    return s;
  endfunction

  task automatic push_sample(input gyro_sample_t s);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic idle_sender(input int n);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
  endtask

  // Write one register, with junk above the register's width
  task automatic write_reg(input logic [IDX_W-1:0] idx, input longint val);
    logic [CFG_W-1:0] mask;
    logic [CFG_W-1:0] data;
    case (idx)
      grc_pkg::CFG_OFFSET_X, grc_pkg::CFG_OFFSET_Y, grc_pkg::CFG_OFFSET_Z:
        mask = CFG_W'((1 << RATE_W) - 1);
      grc_pkg::CFG_DEAD_ZONE: mask = CFG_W'((1 << grc_pkg::DZ_W) - 1);
      grc_pkg::CFG_STILL_SPEED_LIMIT: mask = CFG_W'((1 << grc_pkg::SSL_W) - 1);
      grc_pkg::CFG_STILL_RATE_LIMIT: mask = CFG_W'((1 << grc_pkg::SRL_W) - 1);
      grc_pkg::CFG_YAW_STEP: mask = CFG_W'((1 << grc_pkg::STEP_W) - 1);
      default: mask = '0;
    endcase
    data = (CFG_W'($urandom) & ~mask) | (CFG_W'(val) & mask);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input longint ox, input longint oy, input longint oz,
                               input longint dz, input longint ssl, input longint srl,
                               input longint step);
    drain();
    write_reg(grc_pkg::CFG_OFFSET_X, ox);
    write_reg(grc_pkg::CFG_OFFSET_Y, oy);
    write_reg(grc_pkg::CFG_OFFSET_Z, oz);
    write_reg(grc_pkg::CFG_DEAD_ZONE, dz);
    write_reg(grc_pkg::CFG_STILL_SPEED_LIMIT, ssl);
    write_reg(grc_pkg::CFG_STILL_RATE_LIMIT, srl);
    write_reg(grc_pkg::CFG_YAW_STEP, step);
    settings++;
  endtask

  task automatic run_random(input int n, input int gaps, input int stalls);
    gap_odds = gaps;
    stall_odds = stalls;
    repeat (n) begin
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        idle_sender($urandom_range(1, 10));
      push_sample(random_sample());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    gap_odds = 0;
    stall_odds = 0;
    settings = 1;
    sb = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: lock edges, dead zone edges, field extremes
    push_sample(mk(0, 0, 0, 0, 0));
    push_sample(mk(76, -76, 1279, 1279, -1279));
    push_sample(mk(77, -77, -1280, 1279, -1279));
    push_sample(mk(-77, 77, 5, 1280, 0));
    push_sample(mk(3, 300, -5, 0, -1280));
    push_sample(mk(RATE_MAX, RATE_MAX, RATE_MAX, 8388607, 8388607));
    push_sample(mk(RATE_MIN, RATE_MIN, RATE_MIN, -8388608, -8388608));
    push_sample(mk(RATE_MIN, RATE_MAX, RATE_MAX, -8388608, 8388607));
    push_sample(mk(RATE_MAX, RATE_MIN, RATE_MIN, 8388607, -8388608));
    push_sample(mk(RATE_MAX, RATE_MAX, RATE_MAX, 0, 0));
    push_sample(mk(RATE_MAX, RATE_MAX, RATE_MAX, 0, 0));

    // Extreme offsets and limits; zero limits never lock; stray index is dropped
    apply_setting(RATE_MAX, RATE_MIN, RATE_MAX, 65535, 0, 0, 65535);
    write_reg(CFG_UNUSED, 0);
    push_sample(mk(RATE_MIN, RATE_MAX, RATE_MIN, 0, 0));
    push_sample(mk(RATE_MIN, RATE_MAX, RATE_MIN, 0, 0));
    push_sample(mk(RATE_MAX, RATE_MIN, RATE_MAX, 0, 0));
    push_sample(mk(RATE_MAX - 65534, RATE_MIN + 65535, 0, 1, -1));
    push_sample(mk(RATE_MAX - 65535, RATE_MIN + 65534, RATE_MAX - 1, 5, 5));
    push_sample(mk(0, 0, RATE_MIN, 8388607, -8388608));

    // Random samples over a spread of register settings
    apply_setting(near(0, 3000, RATE_W), near(0, 3000, RATE_W), near(0, 3000, RATE_W),
                  $urandom_range(0, 400), $urandom_range(500, 4000),
                  $urandom_range(200, 3000), $urandom_range(0, 65535));
    run_random(RUN_ITEMS, 4, 4);
    apply_setting(near(0, 3000, RATE_W), near(0, 3000, RATE_W), near(0, 3000, RATE_W),
                  0, 0, 0, 0);
    run_random(RUN_ITEMS, 3, 6);
    apply_setting($urandom, $urandom, $urandom, 65535, 8388607, 524287, 65535);
    run_random(RUN_ITEMS, 5, 3);
    apply_setting($urandom, $urandom, $urandom, $urandom_range(0, 65535),
                  $urandom_range(0, 8388607), $urandom_range(0, 524287),
                  $urandom_range(0, 65535));
    run_random(RUN_ITEMS, 0, 0);
    apply_setting(near(0, 500, RATE_W), near(0, 500, RATE_W), near(0, 500, RATE_W),
                  1, 1, 1, 1);
    run_random(RUN_ITEMS, 2, 2);
    apply_setting(near(0, 2000, RATE_W), near(0, 2000, RATE_W), near(0, 2000, RATE_W),
                  $urandom_range(0, 200), $urandom_range(1000, 20000),
                  $urandom_range(500, 5000), $urandom_range(0, 65535));
    run_random(RUN_ITEMS, 6, 5);

    // Last part, no idling: pin the nav rate high to drive the heading hard
    apply_setting($urandom, $urandom, RATE_MIN, $urandom_range(0, 65535),
                  $urandom_range(0, 8388607), $urandom_range(0, 524287), 65535);
    gap_odds = 0;
    stall_odds = 0;
    repeat (TAIL_ITEMS) begin
      push_sample(mk($urandom, $urandom, $urandom_range(0, RATE_MAX), $urandom, $urandom));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d results checked over %0d register settings", sb.checked, settings);
    $display("z locked %0d times, %0d saturated differences, %0d heading wraps",
             sb.locks, sb.clipped, sb.wraps);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("tb_gyro_rate_conditioner: clean");
    end else begin
      $display("tb_gyro_rate_conditioner: errors");
    end
    $finish;
  end

endmodule
